### hw/rtl/bch_pkg.sv
// Shared types, constants and code tables for the (44,32) BCH codec.
package bch_pkg;

    localparam int CodeBits = 44;
    localparam int DataBits = 32;
    localparam int ParBits  = 12;
    localparam int RomDepth = 1 << ParBits;
    localparam int PosW     = $clog2(CodeBits);
    localparam int QDepth   = 4;
    localparam int QAw      = $clog2(QDepth);

    // Generator rows, indexed by message bit.
    localparam logic [ParBits-1:0] GenRows [DataBits] = '{
        12'h395, 12'h72A, 12'hE54, 12'hF3D, 12'hDEF, 12'h84B, 12'h303, 12'h606,
        12'hC0C, 12'hB8D, 12'h48F, 12'h91E, 12'h1A9, 12'h352, 12'h6A4, 12'hD48,
        12'h905, 12'h19F, 12'h33E, 12'h67C, 12'hCF8, 12'hA65, 12'h75F, 12'hEBE,
        12'hEE9, 12'hE47, 12'hF1B, 12'hDA3, 12'h8D3, 12'h233, 12'h466, 12'h8CC
    };

    typedef enum logic [0:0] {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAN   = 2'd0,
        ST_CORR    = 2'd1,
        ST_UNCORR  = 2'd2
    } t_status;

    typedef struct packed {
        logic [0:0]          opcode;
        logic [DataBits-1:0] message;
        logic [CodeBits-1:0] received;
    } t_in;

    typedef struct packed {
        logic [CodeBits-1:0] codeword_out;
        logic [ParBits-1:0]  syndrome;
        logic [1:0]          status;
    } t_out;

    // Classified work item passed from front to back through the queue.
    typedef struct packed {
        logic                lookup;
        logic [CodeBits-1:0] word;
        logic [ParBits-1:0]  syn;
    } t_work;

    // Pattern memory entry: valid flag over the error pattern.
    typedef struct packed {
        logic                vld;
        logic [CodeBits-1:0] pat;
    } t_rom;

    function automatic logic [ParBits-1:0] check_row(input logic [PosW-1:0] pos);
        logic [PosW-1:0] k;
        k = pos - PosW'(ParBits);
        if (pos < PosW'(ParBits)) begin
            check_row = ParBits'(1) << pos[3:0];
        end else begin
            check_row = GenRows[k[4:0]];
        end
    endfunction

    function automatic logic [ParBits-1:0] make_syndrome(input logic [CodeBits-1:0] w);
        logic [ParBits-1:0] s;
        s = '0;
        for (int i = 0; i < CodeBits; i++) begin
            if (w[i]) begin
                s = s ^ check_row(PosW'(i));
            end
        end
        return s;
    endfunction

    function automatic logic [ParBits-1:0] make_parity(input logic [DataBits-1:0] m);
        logic [ParBits-1:0] p;
        p = '0;
        for (int i = 0; i < DataBits; i++) begin
            if (m[i]) begin
                p = p ^ GenRows[i];
            end
        end
        return p;
    endfunction

endpackage

### hw/rtl/bch_front.sv
// Front end: accept transactions, form parity or syndrome, classify.
module bch_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bch_pkg::t_in    i_in_data,
    input  logic            i_busy,
    input  logic            i_q_full,
    output logic            o_push,
    output bch_pkg::t_work  o_work
);
    import bch_pkg::*;

    logic               r_vld;
    t_work              r_work;
    logic               n_vld;
    t_work              n_work;
    logic               accept;
    logic [ParBits-1:0] par;
    logic [ParBits-1:0] syn;

    assign o_in_stall = i_busy | (r_vld & i_q_full);
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_vld & ~i_q_full;
    assign o_work     = r_work;

    assign par = make_parity(i_in_data.message);
    assign syn = make_syndrome(i_in_data.received);

    always_comb begin
        n_vld  = r_vld;
        n_work = r_work;
        if (accept) begin
            n_vld = 1'b1;
            if (t_op'(i_in_data.opcode) == OP_ENCODE) begin
                n_work.lookup = 1'b0;
                n_work.word   = {i_in_data.message, par};
                n_work.syn    = par;
            end else begin
                n_work.lookup = (syn != '0);
                n_work.word   = i_in_data.received;
                n_work.syn    = syn;
            end
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_work <= n_work;
    end

endmodule

### hw/rtl/bch_queue.sv
// Short queue of classified work items between front and back.
module bch_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bch_pkg::t_work  i_work,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output bch_pkg::t_work  o_work
);
    import bch_pkg::*;

    t_work          r_mem [QDepth];
    logic [QAw-1:0] r_wr_ptr;
    logic [QAw-1:0] r_rd_ptr;
    logic [QAw:0]   r_cnt;

    assign o_full  = (r_cnt == (QAw+1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

### hw/rtl/bch_back.sv
// Back end: pattern memory build after reset, lookup, correction, output register.
module bch_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    output logic            o_busy,
    input  logic            i_q_empty,
    input  bch_pkg::t_work  i_work,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bch_pkg::t_out   o_out_data
);
    import bch_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_FILL1 = 4'b0010,
        S_FILL2 = 4'b0100,
        S_RUN   = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [ParBits-1:0]  r_cnt, n_cnt;
    logic [PosW-1:0]     r_a, n_a;
    logic [PosW-1:0]     r_b, n_b;

    t_rom                r_rom_mem [RomDepth];
    t_rom                r_rom;
    logic                we;
    logic [ParBits-1:0]  waddr;
    t_rom                wdata;

    logic                r_rd_vld;
    t_work               r_rd_item;
    logic                r_out_vld;
    t_out                r_out;
    t_out                n_out;
    logic                out_free;
    logic                rd_adv;

    assign o_busy      = (r_state != S_RUN);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign out_free    = ~r_out_vld | ~i_out_stall;
    assign rd_adv      = r_rd_vld & out_free;
    assign o_pop       = (r_state == S_RUN) & ~i_q_empty & (~r_rd_vld | rd_adv);

    // Build sequencer: clear every entry, then singles, then pairs in order.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_b     = r_b;
        we      = 1'b0;
        waddr   = r_cnt;
        wdata   = '0;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_FILL1;
                    n_a     = '0;
                end
            end
            S_FILL1: begin
                we        = 1'b1;
                waddr     = check_row(r_a);
                wdata.vld = 1'b1;
                wdata.pat = CodeBits'(1) << r_a;
                n_a       = r_a + 1'b1;
                if (r_a == PosW'(CodeBits - 1)) begin
                    n_state = S_FILL2;
                    n_a     = '0;
                    n_b     = PosW'(1);
                end
            end
            S_FILL2: begin
                we        = 1'b1;
                waddr     = check_row(r_a) ^ check_row(r_b);
                wdata.vld = 1'b1;
                wdata.pat = (CodeBits'(1) << r_a) | (CodeBits'(1) << r_b);
                if (r_b == PosW'(CodeBits - 1)) begin
                    if (r_a == PosW'(CodeBits - 2)) begin
                        n_state = S_RUN;
                    end else begin
                        n_a = r_a + 1'b1;
                        n_b = r_a + PosW'(2);
                    end
                end else begin
                    n_b = r_b + 1'b1;
                end
            end
            S_RUN: begin
                we = 1'b0;
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    // Resolve the item in the read stage against its memory entry.
    always_comb begin
        n_out.syndrome     = r_rd_item.syn;
        n_out.codeword_out = r_rd_item.word;
        n_out.status       = ST_CLEAN;
        if (r_rd_item.lookup) begin
            if (r_rom.vld) begin
                n_out.codeword_out = r_rd_item.word ^ r_rom.pat;
                n_out.status       = ST_CORR;
            end else begin
                n_out.status       = ST_UNCORR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_a       <= '0;
            r_b       <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_a     <= n_a;
            r_b     <= n_b;
            if (o_pop) begin
                r_rd_vld <= 1'b1;
            end else if (rd_adv) begin
                r_rd_vld <= 1'b0;
            end
            if (rd_adv) begin
                r_out_vld <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_item <= i_work;
        end
        if (rd_adv) begin
            r_out <= n_out;
        end
    end

    // Pattern memory: one write port for the build, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_rom_mem[waddr] <= wdata;
        end
        if (o_pop) begin
            r_rom <= r_rom_mem[i_work.syn];
        end
    end

endmodule

### hw/rtl/bch_44_32_codec_top.sv
// Top level of the (44,32) double-error-correcting BCH encoder and decoder.
//
//  Channel   Direction   Handshake                 Payload
//  --------  ---------   ------------------------  --------------------------------
//  in        sink        i_in_valid / o_in_stall    i_in_data  (opcode, message, received)
//  out       source      o_out_valid / i_out_stall  o_out_data (codeword_out, syndrome, status)
//
//  Once the pattern memory is built, throughput is one transaction per cycle while the output
//  is not stalled; a valid result passes through the input register, queue, memory read and
//  output register in turn. After reset the block builds its 4096-entry error pattern memory
//  through its single write port: all 4096 entries cleared, then 44 single-bit and 946
//  two-bit writes, with o_in_stall held high the whole time.
//  Reset is synchronous and active low. A stalled output holds its transaction while
//  the front keeps taking input until the four-entry queue fills.
module bch_44_32_codec_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bch_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bch_pkg::t_out  o_out_data
);
    import bch_pkg::*;

    logic  busy;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_work front_work;
    t_work queue_work;

    // Front: compute parity for encode, syndrome for decode, flag lookups.
    bch_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_busy     (busy),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_work     (front_work)
    );

    // Decouple front from back so that an output stall does not stop input at once.
    bch_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_work  (queue_work)
    );

    // Back: look up the error pattern by syndrome, correct, register the result.
    bch_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_busy      (busy),
        .i_q_empty   (q_empty),
        .i_work      (queue_work),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### hw/rtl/bch_checker.sv
// Port-level checker for the BCH codec top level, with its bind.
module bch_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input bch_pkg::t_in   i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input bch_pkg::t_out  o_out_data
);
    import bch_pkg::*;

    // Hold a stalled result transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed or dropped");

    // Come out of reset with nothing to deliver and input blocked for the build.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("activity right after reset");

    // A clean result is either a decoded zero syndrome or encoded parity bits.
    a_clean_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_CLEAN |->
            o_out_data.syndrome == '0 ||
            o_out_data.syndrome == o_out_data.codeword_out[ParBits-1:0])
        else $error("clean result with inconsistent syndrome");

    // Correction or failure only follows a nonzero syndrome.
    a_err_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_CORR ||
                        o_out_data.status == ST_UNCORR) |->
            o_out_data.syndrome != '0)
        else $error("correction status with zero syndrome");

endmodule

bind bch_44_32_codec_top bch_checker u_bch_checker (.*);

### tb/bch_44_32_codec_top_tb.sv
// Self-checking testbench for the (44,32) BCH encoder and decoder with a local prediction model.
module bch_44_32_codec_top_tb;
    import bch_pkg::*;

    localparam int CycleLimit  = 300000;   // startup build plus ~1100 transactions, many times over
    localparam int IdlePct     = 24;       // percent odds: a gap before each sent item, a stall at each receiver edge
    localparam int DrainCycles = 20;       // quiet time at the end, after every owed result is back

    // Generator rows, row 31 in the top slice down to row 0 in the bottom slice.
    localparam logic [DataBits*ParBits-1:0] GenTable = {
        12'h8CC, 12'h466, 12'h233, 12'h8D3, 12'hDA3, 12'hF1B, 12'hE47, 12'hEE9,
        12'hEBE, 12'h75F, 12'hA65, 12'hCF8, 12'h67C, 12'h33E, 12'h19F, 12'h905,
        12'hD48, 12'h6A4, 12'h352, 12'h1A9, 12'h91E, 12'h48F, 12'hB8D, 12'hC0C,
        12'h606, 12'h303, 12'h84B, 12'hDEF, 12'hF3D, 12'hE54, 12'h72A, 12'h395
    };

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    // Results still owed by the block, oldest first.
    t_out exp_results[$];

    // Local copy of the correctable error table, indexed by syndrome.
    logic [CodeBits-1:0] pat_rom [RomDepth];
    bit                  pat_vld [RomDepth];

    int err_cnt   = 0;
    int cycle_cnt = 0;
    int hold_cnt  = 0;   // receiver hold-off, counted down by the receiver process
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    bch_44_32_codec_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("bch_44_32_codec_top_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Code arithmetic
    // ------------------------------------------------------------------

    // Parity-check column for codeword bit pos: unit vectors on the parity
    // bits, generator rows on the message bits.
    function automatic logic [ParBits-1:0] parity_col(input int pos);
        if (pos < ParBits) begin
            return ParBits'(1) << pos;
        end
        return GenTable[(pos-ParBits)*ParBits +: ParBits];
    endfunction

    function automatic logic [ParBits-1:0] calc_syndrome(input logic [CodeBits-1:0] word);
        logic [ParBits-1:0] s;
        s = '0;
        for (int i = 0; i < CodeBits; i++) begin
            if (word[i]) begin
                s ^= parity_col(i);
            end
        end
        return s;
    endfunction

    function automatic logic [ParBits-1:0] calc_parity(input logic [DataBits-1:0] msg);
        logic [ParBits-1:0] p;
        p = '0;
        for (int i = 0; i < DataBits; i++) begin
            if (msg[i]) begin
                p ^= GenTable[i*ParBits +: ParBits];
            end
        end
        return p;
    endfunction

    function automatic logic [CodeBits-1:0] make_codeword(input logic [DataBits-1:0] msg);
        return {msg, calc_parity(msg)};
    endfunction

    // Fill the error table: single-bit patterns first, then two-bit patterns
    // in ascending order; a later pattern takes over a shared syndrome slot.
    task automatic build_pattern_table();
        logic [CodeBits-1:0] pat;
        logic [ParBits-1:0]  s;
        for (int i = 0; i < RomDepth; i++) begin
            pat_rom[i] = '0;
            pat_vld[i] = 1'b0;
        end
        for (int a = 0; a < CodeBits; a++) begin
            pat = CodeBits'(1) << a;
            s = calc_syndrome(pat);
            pat_rom[s] = pat;
            pat_vld[s] = 1'b1;
        end
        for (int a = 0; a < CodeBits - 1; a++) begin
            for (int b = a + 1; b < CodeBits; b++) begin
                pat = (CodeBits'(1) << a) | (CodeBits'(1) << b);
                s = calc_syndrome(pat);
                pat_rom[s] = pat;
                pat_vld[s] = 1'b1;
            end
        end
    endtask

    // Expected result of one accepted transaction.
    function automatic t_out predict_codec(input t_in item);
        t_out               r;
        logic [ParBits-1:0] s;
        if (item.opcode == OP_ENCODE) begin
            r.codeword_out = make_codeword(item.message);
            r.syndrome     = calc_parity(item.message);
            r.status       = ST_CLEAN;
        end else begin
            s              = calc_syndrome(item.received);
            r.syndrome     = s;
            r.codeword_out = item.received;
            r.status       = ST_CLEAN;
            // A zero syndrome never consults the table.
            if (s != '0) begin
                if (pat_vld[s]) begin
                    r.codeword_out = item.received ^ pat_rom[s];
                    r.status       = ST_CORR;
                end else begin
                    r.status       = ST_UNCORR;
                end
            end
        end
        return r;
    endfunction

    function automatic t_in mk_item(input t_op op, input logic [DataBits-1:0] msg,
                                    input logic [CodeBits-1:0] rcv);
        t_in item;
        item.opcode   = op;
        item.message  = msg;
        item.received = rcv;
        return item;
    endfunction

    // Mostly real codewords with up to two flipped bits, some with three to
    // five, some pure noise, and about a third encodes.
    function automatic t_in rand_item();
        t_in                 item;
        int                  kind;
        int                  nerr;
        logic [CodeBits-1:0] flips;
        item = mk_item(OP_DECODE, $urandom, CodeBits'({$urandom, $urandom}));
        kind = $urandom_range(99);
        if (kind < 30) begin
            item.opcode = OP_ENCODE;
            if ($urandom_range(7) == 0) begin
                item.message = $urandom_range(1) ? '1 : '0;
            end
        end else if (kind < 95) begin
            nerr  = (kind < 85) ? $urandom_range(2) : $urandom_range(5, 3);
            flips = '0;
            while ($countones(flips) < nerr) begin
                flips[$urandom_range(CodeBits-1)] = 1'b1;
            end
            item.received = make_codeword($urandom) ^ flips;
        end
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Sender and receiver
    // ------------------------------------------------------------------

    // Offer one transaction and return at the edge that accepts it. Valid
    // stays high into the next call unless an idle gap is drawn.
    task automatic send_item(input t_in item);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(99) < IdlePct) begin
            gap = $urandom_range(4, 1);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        exp_results.push_back(predict_codec(item));
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (exp_results.size() != 0);
    endtask

    task automatic note_error(input string what, input logic [CodeBits-1:0] want,
                              input logic [CodeBits-1:0] got);
        err_cnt++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (exp_results.size() == 0) begin
            err_cnt++;
            $display("%0t: result with nothing outstanding: expected none, actual %h",
                     $time, got);
            return;
        end
        want = exp_results.pop_front();
        if (got.codeword_out !== want.codeword_out) begin
            note_error("codeword_out", want.codeword_out, got.codeword_out);
        end
        if (got.syndrome !== want.syndrome) begin
            note_error("syndrome", CodeBits'(want.syndrome), CodeBits'(got.syndrome));
        end
        if (got.status !== want.status) begin
            note_error("status", CodeBits'(want.status), CodeBits'(got.status));
        end
    endtask

    // Receiver: check each accepted transaction, then draw the stall for
    // the next edge. A pending hold-off overrides the random stall.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                check_result(o_out_data);
            end
            if (hold_cnt > 0) begin
                i_out_stall <= 1'b1;
                hold_cnt--;
            end else begin
                i_out_stall <= rx_idle_en && ($urandom_range(99) < IdlePct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Encode the field extremes; the received field carries junk to prove
    // it is ignored.
    task automatic test_encode_directed();
        send_item(mk_item(OP_ENCODE, 32'h0000_0000, '1));
        send_item(mk_item(OP_ENCODE, 32'hFFFF_FFFF, '0));
        send_item(mk_item(OP_ENCODE, 32'h0000_0001, '1));
        send_item(mk_item(OP_ENCODE, 32'h8000_0000, '0));
        send_item(mk_item(OP_ENCODE, 32'hAAAA_AAAA, 44'h555_5555_5555));
        send_item(mk_item(OP_ENCODE, 32'h5555_5555, 44'hAAA_AAAA_AAAA));
    endtask

    // Decode clean words, single and double errors at the field edges, a
    // shared syndrome slot and a syndrome with no pattern behind it.
    task automatic test_decode_directed();
        logic [CodeBits-1:0] cw;
        logic [CodeBits-1:0] pat;
        logic [CodeBits-1:0] cand;
        logic [ParBits-1:0]  s;
        cw = make_codeword(32'h1234_5678);
        // Zero word and clean codewords pass untouched; all-ones word also sent; message is junk.
        send_item(mk_item(OP_DECODE, '1, '0));
        send_item(mk_item(OP_DECODE, '0, cw));
        send_item(mk_item(OP_DECODE, '1, '1));
        send_item(mk_item(OP_DECODE, '0, make_codeword('1)));
        // Single-bit errors on both ends of the parity and message fields.
        send_item(mk_item(OP_DECODE, '0, cw ^ (CodeBits'(1) << 0)));
        send_item(mk_item(OP_DECODE, '0, cw ^ (CodeBits'(1) << 11)));
        send_item(mk_item(OP_DECODE, '0, cw ^ (CodeBits'(1) << 12)));
        send_item(mk_item(OP_DECODE, '0, cw ^ (CodeBits'(1) << 43)));
        // Double-bit errors across the field boundary and the word ends.
        send_item(mk_item(OP_DECODE, '0, cw ^ ((CodeBits'(1) << 0) | (CodeBits'(1) << 43))));
        send_item(mk_item(OP_DECODE, '0, cw ^ ((CodeBits'(1) << 11) | (CodeBits'(1) << 12))));
        // Find a two-bit pattern whose slot was taken over by a later one.
        pat = '0;
        for (int a = 0; a < CodeBits - 1; a++) begin
            for (int b = a + 1; b < CodeBits; b++) begin
                cand = (CodeBits'(1) << a) | (CodeBits'(1) << b);
                if (pat == '0 && pat_rom[calc_syndrome(cand)] != cand) begin
                    pat = cand;
                end
            end
        end
        if (pat != '0) begin
            send_item(mk_item(OP_DECODE, '0, cw ^ pat));
        end
        // Lowest nonzero syndrome without a pattern: a word of parity bits
        // alone has exactly that syndrome.
        s = '0;
        for (int i = 1; i < RomDepth; i++) begin
            if (s == '0 && !pat_vld[i]) begin
                s = ParBits'(i);
            end
        end
        send_item(mk_item(OP_DECODE, '0, CodeBits'(s)));
        send_item(mk_item(OP_DECODE, '1, cw ^ CodeBits'(s)));
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n) send_item(rand_item());
    endtask

    // Full rate on both sides with no idling at all.
    task automatic test_steady_stream(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (n) send_item(rand_item());
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Hold the output off long enough for the queue to fill and stall the
    // input while the sender keeps offering, then drain completely.
    task automatic test_output_holdoff();
        hold_cnt   = 80;
        tx_idle_en = 1'b0;
        repeat (30) send_item(rand_item());
        tx_idle_en = 1'b1;
        wait_for_results();
    endtask

    task automatic finish_run();
        wait_for_results();
        repeat (DrainCycles) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("bch_44_32_codec_top_tb passed");
        end else begin
            $display("bch_44_32_codec_top_tb failed");
        end
        $finish;
    endtask

    // Reset once, then run the tests in turn. The sender simply waits out the
    // table build after reset since the input stalls the whole time.
    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        build_pattern_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_encode_directed();
        test_decode_directed();
        wait_for_results();
        test_random_traffic(400);
        test_steady_stream(250);
        test_output_holdoff();
        test_random_traffic(400);
        finish_run();
    end

endmodule

### bch_44_32_codec_top.f
hw/rtl/bch_pkg.sv
hw/rtl/bch_front.sv
hw/rtl/bch_queue.sv
hw/rtl/bch_back.sv
hw/rtl/bch_44_32_codec_top.sv
hw/rtl/bch_checker.sv
tb/bch_44_32_codec_top_tb.sv
